@@ rtl/bootloader_frame_decoder_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the boot loader frame decoder.
// Each macro expects a clock named clk and an active-low reset named rst_n.
// ----------------------------------------------------------------------------
`ifndef BOOTLOADER_FRAME_DECODER_ASSERT_SVH
`define BOOTLOADER_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication.
`define BFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define BFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/bfd_pkg.sv @@
// ----------------------------------------------------------------------------
// bfd_pkg
// Types and constants shared by the boot loader frame decoder files.
// ----------------------------------------------------------------------------
package bfd_pkg;

    localparam int PAYLOAD_DEPTH_DEF = 128;

    localparam logic [7:0] CHR_START = 8'h21;  // '!'
    localparam logic [7:0] CHR_ACK   = 8'h41;  // 'A'
    localparam logic [7:0] CHR_NACK  = 8'h4E;  // 'N'

    localparam logic [7:0] CMD_ERASE     = 8'h41;  // 'A'
    localparam logic [7:0] CMD_WRITE     = 8'h42;  // 'B'
    localparam logic [7:0] CMD_BANK      = 8'h43;  // 'C'
    localparam logic [7:0] CMD_TMO_ON    = 8'h44;  // 'D'
    localparam logic [7:0] CMD_READ      = 8'h45;  // 'E'
    localparam logic [7:0] CMD_TMO_OFF   = 8'h46;  // 'F'
    localparam logic [7:0] CMD_SIGNATURE = 8'h48;  // 'H'

    localparam logic [7:0] SIGNATURE_RESET = 8'h10;

    localparam logic [7:0] CMD_FRAME_LEN  = 8'd2;
    localparam logic [7:0] FILL_FRAME_LEN = 8'd66;
    // Index of the low byte of the final fill word.
    localparam logic [6:0] FILL_LAST_IDX  = 7'd64;
    localparam logic [6:0] FILL_FIRST_IDX = 7'd2;

    localparam logic [3:0] ACT_SEND     = 4'd0;
    localparam logic [3:0] ACT_ERASE    = 4'd1;
    localparam logic [3:0] ACT_WRITE    = 4'd2;
    localparam logic [3:0] ACT_FILL     = 4'd3;
    localparam logic [3:0] ACT_READ     = 4'd4;
    localparam logic [3:0] ACT_BANK_LO  = 4'd5;
    localparam logic [3:0] ACT_BANK_HI  = 4'd6;
    localparam logic [3:0] ACT_TMO_ON   = 4'd7;
    localparam logic [3:0] ACT_TMO_OFF  = 4'd8;

    typedef enum logic [3:0] {
        ST_HUNT,
        ST_LEN,
        ST_CMD,
        ST_DATA,
        ST_RD0,
        ST_RD1,
        ST_DECODE,
        ST_FILL_RD0,
        ST_FILL_RD1,
        ST_FILL_PUT,
        ST_ACK
    } state_t;

endpackage

@@ rtl/bootloader_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// bootloader_frame_decoder
// Decodes serial boot loader frames into flash actions and ACK/NACK bytes.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  in        in_valid / in_ready   rx_byte, char_timeout
//  out       out_valid / out_ready action, flash_address, fill_word, tx_byte, last
//  cfg       cfg_valid / cfg_ready cfg_data (signature byte)
//
// Received bytes are taken in the hunt, length, command and data states.
// After the final byte of a frame the input stalls while the payload RAM is
// read back through its single read port: RD0 and RD1 read the two address
// bytes, then the decode state loads the command result or the NACK, and the
// ACK state follows a command result. After the decode state a fill frame
// reads each fill word in FILL_RD0 and FILL_RD1 and loads it in FILL_PUT,
// then sends the ACK; the input is held off until the ACK is loaded.
// A stalled output holds the sequencer in place; no result is dropped.
// Reset returns the decoder to hunting for the start character.
// ----------------------------------------------------------------------------
module bootloader_frame_decoder #(
    parameter int PAYLOAD_DEPTH = bfd_pkg::PAYLOAD_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        char_timeout,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  action,
    output logic [15:0] flash_address,
    output logic [15:0] fill_word,
    output logic [7:0]  tx_byte,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import bfd_pkg::*;

    localparam int AW = $clog2(PAYLOAD_DEPTH);

    state_t      state_reg, state_next;
    logic [7:0]  signature_reg;
    logic [7:0]  len_reg;
    logic [7:0]  cmd_reg;
    logic [8:0]  count_reg;
    logic [7:0]  xor_reg;
    logic [7:0]  lo_reg;
    logic [6:0]  idx_reg;
    logic [15:0] addr_reg;

    logic        out_valid_reg;
    logic [3:0]  action_reg;
    logic [15:0] address_reg;
    logic [15:0] word_reg;
    logic [7:0]  tx_reg;
    logic        last_reg;

    logic          accept;
    logic          slot_free;
    logic [8:0]    count_inc;
    logic          frame_done;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;
    logic          frame_ok;
    logic [15:0]   start_addr;
    logic          cmd_known;
    logic [3:0]    cmd_action;
    logic [15:0]   cmd_address;
    logic [7:0]    cmd_tx;

    logic          emit;
    logic [3:0]    emit_action;
    logic [15:0]   emit_address;
    logic [15:0]   emit_word;
    logic [7:0]    emit_tx;
    logic          emit_last;

    assign accept     = in_valid && in_ready;
    assign slot_free  = !out_valid_reg || out_ready;
    assign count_inc  = count_reg + 9'd1;
    assign frame_done = count_inc >= ({1'b0, len_reg} + 9'd1);
    assign ram_wr_en  = accept && !char_timeout && (state_reg == ST_DATA)
                        && (count_reg < 9'(PAYLOAD_DEPTH));
    assign frame_ok   = (xor_reg == 8'd0);
    assign start_addr = {ram_rd_data, lo_reg};
    assign cfg_ready  = 1'b1;

    bfd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_payload (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Command decode for a length-2 frame; lo_reg holds the first data byte.
    always_comb
    begin
        cmd_known   = 1'b1;
        cmd_action  = ACT_SEND;
        cmd_address = 16'd0;
        cmd_tx      = 8'd0;
        case (cmd_reg)
            CMD_ERASE:
            begin
                cmd_action  = ACT_ERASE;
                cmd_address = start_addr;
            end
            CMD_WRITE:
            begin
                cmd_action  = ACT_WRITE;
                cmd_address = start_addr;
            end
            CMD_BANK:      cmd_action = (lo_reg == 8'd0) ? ACT_BANK_LO : ACT_BANK_HI;
            CMD_TMO_ON:    cmd_action = ACT_TMO_ON;
            CMD_READ:
            begin
                cmd_action  = ACT_READ;
                cmd_address = start_addr;
            end
            CMD_TMO_OFF:   cmd_action = ACT_TMO_OFF;
            CMD_SIGNATURE: cmd_tx = signature_reg;
            default:       cmd_known = 1'b0;
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
            begin
                if (accept && !char_timeout && (rx_byte == CHR_START))
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (accept)
                begin
                    state_next = char_timeout ? ST_HUNT : ST_CMD;
                end
            end
            ST_CMD:
            begin
                if (accept)
                begin
                    state_next = char_timeout ? ST_HUNT : ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (accept)
                begin
                    if (char_timeout)
                    begin
                        state_next = ST_HUNT;
                    end
                    else if (frame_done)
                    begin
                        state_next = ST_RD0;
                    end
                end
            end
            ST_RD0: state_next = ST_RD1;
            ST_RD1: state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (frame_ok && (len_reg == FILL_FRAME_LEN))
                begin
                    state_next = ST_FILL_RD0;
                end
                else if (slot_free)
                begin
                    if (frame_ok && (len_reg == CMD_FRAME_LEN) && cmd_known)
                    begin
                        state_next = ST_ACK;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_FILL_RD0: state_next = ST_FILL_RD1;
            ST_FILL_RD1: state_next = ST_FILL_PUT;
            ST_FILL_PUT:
            begin
                if (slot_free)
                begin
                    state_next = (idx_reg == FILL_LAST_IDX) ? ST_ACK : ST_FILL_RD0;
                end
            end
            ST_ACK:
            begin
                if (slot_free)
                begin
                    state_next = ST_HUNT;
                end
            end
            default: state_next = ST_HUNT;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        in_ready     = 1'b0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = '0;
        emit         = 1'b0;
        emit_action  = ACT_SEND;
        emit_address = 16'd0;
        emit_word    = 16'd0;
        emit_tx      = 8'd0;
        emit_last    = 1'b0;
        case (state_reg)
            ST_HUNT, ST_LEN, ST_CMD, ST_DATA: in_ready = 1'b1;
            ST_RD0:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(0);
            end
            ST_RD1:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(1);
            end
            ST_DECODE:
            begin
                if (!(frame_ok && (len_reg == FILL_FRAME_LEN)) && slot_free)
                begin
                    emit = 1'b1;
                    if (frame_ok && (len_reg == CMD_FRAME_LEN) && cmd_known)
                    begin
                        emit_action  = cmd_action;
                        emit_address = cmd_address;
                        emit_tx      = cmd_tx;
                    end
                    else
                    begin
                        emit_tx   = CHR_NACK;
                        emit_last = 1'b1;
                    end
                end
            end
            ST_FILL_RD0:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(idx_reg);
            end
            ST_FILL_RD1:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = AW'(idx_reg + 7'd1);
            end
            ST_FILL_PUT:
            begin
                emit         = slot_free;
                emit_action  = ACT_FILL;
                emit_address = addr_reg;
                emit_word    = {ram_rd_data, lo_reg};
            end
            ST_ACK:
            begin
                emit      = slot_free;
                emit_tx   = CHR_ACK;
                emit_last = 1'b1;
            end
            default: in_ready = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_HUNT;
            signature_reg <= SIGNATURE_RESET;
            len_reg       <= 8'd0;
            cmd_reg       <= 8'd0;
            count_reg     <= 9'd0;
            xor_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                signature_reg <= cfg_data;
            end
            if (accept)
            begin
                if (char_timeout)
                begin
                    if (state_reg != ST_HUNT)
                    begin
                        count_reg <= 9'd0;
                        xor_reg   <= 8'd0;
                    end
                end
                else
                begin
                    case (state_reg)
                        ST_HUNT:
                        begin
                            if (rx_byte == CHR_START)
                            begin
                                count_reg <= 9'd0;
                                xor_reg   <= 8'd0;
                            end
                        end
                        ST_LEN:
                        begin
                            len_reg <= rx_byte;
                            xor_reg <= xor_reg ^ rx_byte;
                        end
                        ST_CMD:
                        begin
                            cmd_reg   <= rx_byte;
                            xor_reg   <= xor_reg ^ rx_byte;
                            count_reg <= 9'd0;
                        end
                        default:
                        begin
                            xor_reg   <= xor_reg ^ rx_byte;
                            count_reg <= frame_done ? 9'd0 : count_inc;
                        end
                    endcase
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_RD1) || (state_reg == ST_FILL_RD1))
        begin
            lo_reg <= ram_rd_data;
        end
        if (state_reg == ST_DECODE)
        begin
            addr_reg <= start_addr;
            idx_reg  <= FILL_FIRST_IDX;
        end
        else if ((state_reg == ST_FILL_PUT) && slot_free)
        begin
            addr_reg <= addr_reg + 16'd2;
            idx_reg  <= idx_reg + 7'd2;
        end
        if (emit)
        begin
            action_reg  <= emit_action;
            address_reg <= emit_address;
            word_reg    <= emit_word;
            tx_reg      <= emit_tx;
            last_reg    <= emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign flash_address = address_reg;
    assign fill_word     = word_reg;
    assign tx_byte       = tx_reg;
    assign last          = last_reg;

endmodule

@@ rtl/bfd_ram.sv @@
// ----------------------------------------------------------------------------
// bfd_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // The read data holds until the next read is issued.
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/bfd_checker.sv @@
// ----------------------------------------------------------------------------
// bfd_checker
// Port-level checks on the frame decoder's result channel.
// ----------------------------------------------------------------------------
`include "bootloader_frame_decoder_assert.svh"

module bfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  action,
    input logic [15:0] flash_address,
    input logic [15:0] fill_word,
    input logic [7:0]  tx_byte,
    input logic        last
);
    import bfd_pkg::*;

    // A stalled result keeps its payload.
    `BFD_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(action) && $stable(flash_address) && $stable(fill_word) && $stable(tx_byte) && $stable(last))

    // The closing result of a frame is always an ACK or a NACK send.
    `BFD_ASSERT_NOW(a_close, out_valid && last, (action == ACT_SEND) && (flash_address == 16'd0) && ((tx_byte == CHR_ACK) || (tx_byte == CHR_NACK)))

    // Fill words never close a frame and carry no transmit byte.
    `BFD_ASSERT_NOW(a_fill, out_valid && (action == ACT_FILL), !last && (tx_byte == 8'd0))

    // While a result other than the close is waiting, the input is held off.
    `BFD_ASSERT_NOW(a_burst, out_valid && !last, !in_ready)

endmodule

bind bootloader_frame_decoder bfd_checker u_bfd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .action        (action),
    .flash_address (flash_address),
    .fill_word     (fill_word),
    .tx_byte       (tx_byte),
    .last          (last)
);
